[design/qtok_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtok_pkg: shared types and constants for the quoted tokenizer
// Result record, per-item result bundle, character codes, queue sizing.
// ----------------------------------------------------------------------------
package qtok_pkg;

    localparam int MaxRes = 3;   // bundle room; one item causes at most two results
    localparam int QDepth = 4;   // bundle queue between front and back
    localparam int QAw    = $clog2(QDepth);

    localparam logic [7:0] ChDquote = 8'h22;
    localparam logic [7:0] ChSquote = 8'h27;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChLowerN = 8'h6E;
    localparam logic [7:0] ChLowerT = 8'h74;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] CaseDiff = 8'h20;

    typedef struct packed {
        logic [7:0] token_byte;
        logic       byte_valid;
        logic       token_end;
        logic       is_command_name;
        logic       empty_command;
        logic       line_done;
    } t_result;

    typedef struct packed {
        logic [1:0]              cnt;
        t_result [MaxRes-1:0]    res;
    } t_bundle;

endpackage

[design/qtok_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtok_front: byte classifier and scan mode machine
// Accepts one byte per cycle while the queue has room, decodes quotes and
// escapes, and packs the byte's results into one bundle for the queue.
// ----------------------------------------------------------------------------
module qtok_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_line_byte,
    input  logic              i_last_of_line,
    input  logic              i_q_full,
    output logic              o_push,
    output qtok_pkg::t_bundle o_bundle
);
    import qtok_pkg::*;

    typedef enum logic [2:0] {
        M_BETWEEN,
        M_PLAIN,
        M_DQUOTE,
        M_DQ_ESC,
        M_SQUOTE
    } t_mode;

    typedef struct packed {
        logic [1:0]           n;
        t_result [MaxRes-1:0] res;
        logic                 ts;
        t_mode                mode;
    } t_acc;

    t_mode r_mode;
    logic  r_seen;
    t_acc  a;
    logic  blank;
    logic  accept;

    function automatic t_acc acc_put(t_acc ai, logic [7:0] b);
        t_acc       r;
        logic [7:0] c;
        r = ai;
        c = b;
        if (!ai.ts && (b inside {[8'h61:8'h7A]})) begin
            c = b - CaseDiff;
        end
        r.res[ai.n] = '{token_byte: c, byte_valid: 1'b1, token_end: 1'b0,
                        is_command_name: !ai.ts, empty_command: 1'b0,
                        line_done: 1'b0};
        r.n = ai.n + 2'd1;
        return r;
    endfunction

    function automatic t_acc acc_end(t_acc ai);
        t_acc r;
        r = ai;
        if (ai.n != 2'd0) begin
            r.res[ai.n - 2'd1].token_end = 1'b1;
        end else begin
            // bare end mark, tagged as its token would be
            r.res[0] = '{token_byte: 8'h00, byte_valid: 1'b0, token_end: 1'b1,
                         is_command_name: !ai.ts, empty_command: 1'b0,
                         line_done: 1'b0};
            r.n = 2'd1;
        end
        r.ts   = 1'b1;
        r.mode = M_BETWEEN;
        return r;
    endfunction

    assign blank  = (i_line_byte == 8'h20) || (i_line_byte inside {[8'h09:8'h0D]});
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        a      = '0;
        a.ts   = r_seen;
        a.mode = r_mode;
        case (r_mode)
            M_PLAIN: begin
                if (blank) a = acc_end(a);
                else       a = acc_put(a, i_line_byte);
            end
            M_DQUOTE: begin
                if (i_line_byte == ChDquote)      a = acc_end(a);
                else if (i_line_byte == ChBslash) a.mode = M_DQ_ESC;
                else                              a = acc_put(a, i_line_byte);
            end
            M_DQ_ESC: begin
                if (i_line_byte == ChDquote || i_line_byte == ChBslash) begin
                    a = acc_put(a, i_line_byte);
                end else if (i_line_byte == ChLowerN) begin
                    a = acc_put(a, ChLf);
                end else if (i_line_byte == ChLowerT) begin
                    a = acc_put(a, ChTab);
                end else begin
                    // unknown escape keeps its backslash
                    a = acc_put(a, ChBslash);
                    a = acc_put(a, i_line_byte);
                end
                a.mode = M_DQUOTE;
            end
            M_SQUOTE: begin
                if (i_line_byte == ChSquote) a = acc_end(a);
                else                         a = acc_put(a, i_line_byte);
            end
            default: begin
                a.mode = M_BETWEEN;
                if (blank) begin
                    a.mode = M_BETWEEN;
                end else if (i_line_byte == ChDquote) begin
                    a.mode = M_DQUOTE;
                end else if (i_line_byte == ChSquote) begin
                    a.mode = M_SQUOTE;
                end else begin
                    a.mode = M_PLAIN;
                    a = acc_put(a, i_line_byte);
                end
            end
        endcase

        if (i_last_of_line) begin
            if (a.mode == M_DQ_ESC) a = acc_put(a, ChBslash);
            if (a.mode != M_BETWEEN) a = acc_end(a);
            if (!a.ts) begin
                a.res[a.n] = '{token_byte: 8'h00, byte_valid: 1'b0, token_end: 1'b0,
                               is_command_name: 1'b0, empty_command: 1'b1,
                               line_done: 1'b1};
                a.n = a.n + 2'd1;
            end else if (a.n != 2'd0) begin
                a.res[a.n - 2'd1].line_done = 1'b1;
            end else begin
                a.res[0] = '{token_byte: 8'h00, byte_valid: 1'b0, token_end: 1'b0,
                             is_command_name: 1'b0, empty_command: 1'b0,
                             line_done: 1'b1};
                a.n = 2'd1;
            end
            a.mode = M_BETWEEN;
            a.ts   = 1'b0;
        end
    end

    assign o_push       = accept && (a.n != 2'd0);
    assign o_bundle.cnt = a.n;
    assign o_bundle.res = a.res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_BETWEEN;
            r_seen <= 1'b0;
        end else if (accept) begin
            r_mode <= a.mode;
            r_seen <= a.ts;
        end
    end

endmodule

[design/qtok_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtok_fifo: bundle queue
// Small register queue that decouples the mode machine from the output side.
// ----------------------------------------------------------------------------
module qtok_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  qtok_pkg::t_bundle i_bundle,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output qtok_pkg::t_bundle o_bundle
);
    import qtok_pkg::*;

    t_bundle        r_mem [QDepth];
    logic [QAw-1:0] r_wr;
    logic [QAw-1:0] r_rd;
    logic [QAw:0]   r_cnt;

    assign o_full   = (r_cnt == QDepth[QAw:0]);
    assign o_valid  = (r_cnt != '0);
    assign o_bundle = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + {{QAw{1'b0}}, i_push} - {{QAw{1'b0}}, i_pop};
        end
    end

endmodule

[design/qtok_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtok_back: result serializer
// Pops bundles and hands their results out one per cycle from an output
// register, while i_ready does not hold it back.
// ----------------------------------------------------------------------------
module qtok_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  qtok_pkg::t_bundle i_bundle,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output qtok_pkg::t_result o_result
);
    import qtok_pkg::*;

    logic    r_valid;
    logic    r_busy;
    logic [1:0] r_idx;
    t_bundle r_bun;
    t_result r_out;
    logic    out_free;

    assign out_free = !r_valid || i_ready;
    assign o_pop    = out_free && !r_busy && i_q_valid;
    assign o_valid  = r_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_idx   <= 2'd0;
        end else if (out_free) begin
            if (r_busy) begin
                r_out   <= r_bun.res[r_idx];
                r_valid <= 1'b1;
                r_idx   <= r_idx + 2'd1;
                if (r_idx == r_bun.cnt - 2'd1) r_busy <= 1'b0;
            end else if (i_q_valid) begin
                r_out   <= i_bundle.res[0];
                r_valid <= 1'b1;
                r_bun   <= i_bundle;
                r_idx   <= 2'd1;
                r_busy  <= (i_bundle.cnt > 2'd1);
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

[design/quoted_command_line_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_command_line_tokenizer: shell-style command line tokenizer
// Splits a byte stream into tokens with quote and escape decoding.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------
//   in      | input     | i_valid / o_ready   | i_line_byte, i_last_of_line
//   out     | output    | o_valid / i_ready   | o_token_byte, o_byte_valid,
//           |           |                     | o_token_end, o_is_command_name,
//           |           |                     | o_empty_command, o_line_done
//
// One input byte per cycle while o_ready is high. A byte that causes two results
// holds the output side for each of them in turn; a four-deep bundle queue absorbs this.
// Results pass through the bundle queue and then the output register.
// Reset is synchronous and active low.
// o_ready drops only when the bundle queue is full.
// ----------------------------------------------------------------------------
module quoted_command_line_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_line_byte,
    input  logic       i_last_of_line,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_token_byte,
    output logic       o_byte_valid,
    output logic       o_token_end,
    output logic       o_is_command_name,
    output logic       o_empty_command,
    output logic       o_line_done
);
    import qtok_pkg::*;

    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_valid;
    t_bundle push_bundle;
    t_bundle head_bundle;
    t_result result;

    qtok_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_line_byte    (i_line_byte),
        .i_last_of_line (i_last_of_line),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_bundle       (push_bundle)
    );

    qtok_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_bundle (head_bundle)
    );

    qtok_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_bundle  (head_bundle),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (result)
    );

    assign o_token_byte      = result.token_byte;
    assign o_byte_valid      = result.byte_valid;
    assign o_token_end       = result.token_end;
    assign o_is_command_name = result.is_command_name;
    assign o_empty_command   = result.empty_command;
    assign o_line_done       = result.line_done;

endmodule

[verif/tb_quoted_command_line_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quoted_command_line_tokenizer: self-checking bench for the tokenizer
// A short directed table covers quoting, escapes, uppercasing and empty lines.
// Random lines follow, mostly well-formed with some raw noise lines. Both
// handshakes idle at random. A local scan-state predictor computes each
// item's results, and the output side checks them field by field in order.
// ----------------------------------------------------------------------------
module tb_quoted_command_line_tokenizer;
    import qtok_pkg::*;

    typedef enum logic [2:0] {
        ScanBetween, ScanPlain, ScanDquote, ScanDqEsc, ScanSquote
    } t_scan;

    typedef struct packed {
        logic       typed;   // want holds a hand-written expectation
        logic       last;
        logic [7:0] b;
        t_result    want;
    } t_line_item;

    localparam int NumDirected = 27;
    localparam int NumRandom   = 393;
    localparam int IdlePct     = 34;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_line_byte;
    logic       i_last_of_line;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_token_byte;
    logic       o_byte_valid;
    logic       o_token_end;
    logic       o_is_command_name;
    logic       o_empty_command;
    logic       o_line_done;

    t_line_item line_q[$];
    t_result    step_out[$];
    t_result    token_out_q[$];
    t_line_item dir_tab[NumDirected];
    t_scan      scan_st;
    logic       name_done;
    int         drv_idx;
    int         err_cnt;

    // both sides run without idling through this stretch of items
    wire calm = (drv_idx >= 200) && (drv_idx < 320);

    quoted_command_line_tokenizer u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_line_byte       (i_line_byte),
        .i_last_of_line    (i_last_of_line),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_token_byte      (o_token_byte),
        .o_byte_valid      (o_byte_valid),
        .o_token_end       (o_token_end),
        .o_is_command_name (o_is_command_name),
        .o_empty_command   (o_empty_command),
        .o_line_done       (o_line_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_result mk_res(logic [7:0] b, logic v, logic te, logic cmd,
                                       logic emp, logic done);
        t_result r;
        r.token_byte      = b;
        r.byte_valid      = v;
        r.token_end       = te;
        r.is_command_name = cmd;
        r.empty_command   = emp;
        r.line_done       = done;
        return r;
    endfunction

    function automatic t_line_item row(logic [7:0] b, logic last);
        t_line_item it;
        it      = '0;
        it.b    = b;
        it.last = last;
        return it;
    endfunction

    function automatic t_line_item row_chk(logic [7:0] b, logic last, t_result want);
        t_line_item it;
        it       = row(b, last);
        it.typed = 1'b1;
        it.want  = want;
        return it;
    endfunction

    // ---------------- predictor ----------------

    function automatic bit is_blank(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic void emit_char(logic [7:0] b);
        t_result r;
        r                 = '0;
        r.is_command_name = !name_done;
        r.byte_valid      = 1'b1;
        r.token_byte      = (!name_done && b >= "a" && b <= "z") ? b - CaseDiff : b;
        step_out = {step_out, r};
    endfunction

    function automatic void close_token();
        t_result r;
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.token_end = 1'b1;
        end else begin
            r = mk_res(8'h00, 1'b0, 1'b1, !name_done, 1'b0, 1'b0);
        end
        step_out = {step_out, r};
        name_done = 1'b1;
        scan_st   = ScanBetween;
    endfunction

    function automatic void tokenize_byte(logic [7:0] b, logic last);
        t_result r;
        step_out.delete();
        case (scan_st)
            ScanPlain: begin
                if (is_blank(b)) close_token();
                else emit_char(b);
            end
            ScanDquote: begin
                if (b == ChDquote) close_token();
                else if (b == ChBslash) scan_st = ScanDqEsc;
                else emit_char(b);
            end
            ScanDqEsc: begin
                if (b == ChDquote || b == ChBslash) begin
                    emit_char(b);
                end else if (b == ChLowerN) begin
                    emit_char(ChLf);
                end else if (b == ChLowerT) begin
                    emit_char(ChTab);
                end else begin
                    emit_char(ChBslash);
                    emit_char(b);
                end
                scan_st = ScanDquote;
            end
            ScanSquote: begin
                if (b == ChSquote) close_token();
                else emit_char(b);
            end
            default: begin
                scan_st = ScanBetween;
                if (is_blank(b)) begin
                end else if (b == ChDquote) begin
                    scan_st = ScanDquote;
                end else if (b == ChSquote) begin
                    scan_st = ScanSquote;
                end else begin
                    scan_st = ScanPlain;
                    emit_char(b);
                end
            end
        endcase
        if (last) begin
            // a backslash still pending at line end comes out literally
            if (scan_st == ScanDqEsc) emit_char(ChBslash);
            if (scan_st != ScanBetween) close_token();
            if (!name_done) begin
                step_out = {step_out, mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1)};
            end else if (step_out.size() > 0) begin
                r = step_out.pop_back();
                r.line_done = 1'b1;
                step_out = {step_out, r};
            end else begin
                step_out = {step_out, mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1)};
            end
            scan_st   = ScanBetween;
            name_done = 1'b0;
        end
    endfunction

    // ---------------- random lines ----------------

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(6);
        return (r >= 5) ? 8'h20 : 8'h09 + r[7:0];
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 8'("a" + $urandom_range(25));
        else if (r < 60) return 8'($urandom_range(8'h7E, 8'h21));
        else if (r < 72) return ChBslash;
        else if (r < 80) return $urandom_range(1) ? ChLowerN : ChLowerT;
        else if (r < 92) return 8'(8'h80 + $urandom_range(127));
        else return 8'($urandom_range(255));
    endfunction

    function automatic void push_byte(logic [7:0] b);
        line_q = {line_q, row(b, 1'b0)};
    endfunction

    function automatic void add_token();
        int         kind;
        int         len;
        logic [7:0] c;
        kind = $urandom_range(9);
        len  = $urandom_range(5);
        if (kind < 5) begin
            for (int i = 0; i <= len; i++) push_byte(pick_char());
        end else if (kind < 8) begin
            push_byte(ChDquote);
            for (int i = 0; i < len; i++) begin
                c = pick_char();
                if (c == ChBslash) begin
                    push_byte(c);
                    push_byte($urandom_range(3) == 0 ? ChDquote : pick_char());
                end else if (c != ChDquote) begin
                    push_byte(c);
                end
            end
            if ($urandom_range(9) != 0) push_byte(ChDquote);
        end else begin
            push_byte(ChSquote);
            for (int i = 0; i < len; i++) begin
                c = pick_char();
                if (c != ChSquote) push_byte(c);
            end
            if ($urandom_range(9) != 0) push_byte(ChSquote);
        end
    endfunction

    function automatic void add_line();
        int         first;
        int         ntok;
        t_line_item it;
        first = line_q.size();
        if ($urandom_range(4) == 0) begin
            // raw noise line
            repeat ($urandom_range(10, 1)) push_byte(8'($urandom_range(255)));
        end else begin
            ntok = $urandom_range(3);
            if ($urandom_range(3) == 0) push_byte(pick_blank());
            for (int t = 0; t < ntok; t++) begin
                add_token();
                if (t < ntok - 1 || $urandom_range(1))
                    repeat ($urandom_range(2)) push_byte(pick_blank());
            end
        end
        if (line_q.size() == first) push_byte(pick_blank());
        it = line_q.pop_back();
        it.last = 1'b1;
        line_q = {line_q, it};
    endfunction

    // ---------------- input side ----------------

    initial begin
        bit         took;
        t_line_item it;
        i_valid        <= 1'b0;
        i_line_byte    <= 8'h00;
        i_last_of_line <= 1'b0;
        drv_idx        = 0;
        scan_st        = ScanBetween;
        name_done      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                took = i_valid && o_ready;
                if (took) begin
                    it = line_q[drv_idx];
                    tokenize_byte(it.b, it.last);
                    if (it.typed) token_out_q = {token_out_q, it.want};
                    else token_out_q = {token_out_q, step_out};
                    drv_idx++;
                end
                if (!i_valid || took) begin
                    if (drv_idx < line_q.size() &&
                        (calm || $urandom_range(99) >= IdlePct)) begin
                        i_valid        <= 1'b1;
                        i_line_byte    <= line_q[drv_idx].b;
                        i_last_of_line <= line_q[drv_idx].last;
                    end else begin
                        i_valid <= 1'b0;
                    end
                end
            end
        end
    end

    // ---------------- output side ----------------

    function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    initial begin
        t_result w;
        i_ready <= 1'b0;
        err_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (token_out_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, got byte %0h",
                             $time, o_token_byte);
                end else begin
                    w = token_out_q.pop_front();
                    cmp_field("token_byte", w.token_byte, o_token_byte);
                    cmp_field("byte_valid", {7'd0, w.byte_valid}, {7'd0, o_byte_valid});
                    cmp_field("token_end", {7'd0, w.token_end}, {7'd0, o_token_end});
                    cmp_field("is_command_name", {7'd0, w.is_command_name},
                              {7'd0, o_is_command_name});
                    cmp_field("empty_command", {7'd0, w.empty_command},
                              {7'd0, o_empty_command});
                    cmp_field("line_done", {7'd0, w.line_done}, {7'd0, o_line_done});
                end
            end
            i_ready <= calm || ($urandom_range(99) >= IdlePct);
        end
    end

    // ---------------- sequence ----------------

    initial begin
        i_rst_n <= 1'b0;
        dir_tab = '{
            row_chk("a", 1'b1, mk_res("A", 1'b1, 1'b1, 1'b1, 1'b0, 1'b1)),
            row_chk(8'h20, 1'b1, mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1)),
            row_chk(8'hFF, 1'b1, mk_res(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1)),
            row_chk(8'h00, 1'b1, mk_res(8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1)),
            row("z", 1'b0),
            row(ChDquote, 1'b0),      // quote inside a plain token is a plain byte
            row(8'h0B, 1'b0),         // VT: bare token end on the command name
            row(ChDquote, 1'b0),
            row(ChBslash, 1'b0),
            row(ChLowerN, 1'b0),
            row(ChBslash, 1'b0),
            row(ChLowerT, 1'b0),
            row(ChBslash, 1'b0),
            row(ChDquote, 1'b0),
            row(ChBslash, 1'b0),
            row(ChBslash, 1'b0),
            row(ChBslash, 1'b0),
            row("q", 1'b0),           // unknown escape: backslash plus byte
            row(ChDquote, 1'b0),
            row(ChSquote, 1'b0),      // starts right after the closing quote
            row(ChBslash, 1'b0),
            row(ChSquote, 1'b0),
            row(ChDquote, 1'b0),
            row(ChDquote, 1'b0),      // empty quoted token
            row(ChDquote, 1'b0),
            row(ChBslash, 1'b1),      // line ends with escape pending
            row_chk(8'h0C, 1'b1, mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1))
        };
        foreach (dir_tab[k]) line_q = {line_q, dir_tab[k]};
        while (line_q.size() < NumDirected + NumRandom) add_line();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (drv_idx < line_q.size()) @(posedge i_clk);
        while (token_out_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_quoted_command_line_tokenizer: done, clean");
        end else begin
            $display("tb_quoted_command_line_tokenizer: done, errors");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("%0t: timeout, %0d results still expected", $time, token_out_q.size());
        $display("tb_quoted_command_line_tokenizer: done, errors");
        $finish;
    end

endmodule
